// ===== sv/ecfd_pkg.sv =====
`timescale 1ns / 1ps

package ecfd_pkg;

    localparam int MAX_FRAME = 64;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MARKER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIVER_ENABLE = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ecfd_wr_t;

    typedef struct packed {
        logic             fire;
        logic             empty;
        logic [CNT_W-1:0] count;
    } ecfd_evt_t;

endpackage

// ===== sv/ecfd_ram.sv =====
`timescale 1ns / 1ps

module ecfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/ecfd_parser.sv =====
`timescale 1ns / 1ps

module ecfd_parser
    import ecfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 accept,
    input  logic [BYTE_W-1:0]    rx_byte,
    output ecfd_wr_t             wr,
    output ecfd_evt_t            evt
);

    localparam logic [1:0] MODE_WAIT      = 2'd0;
    localparam logic [1:0] MODE_WAIT_ESC  = 2'd1;
    localparam logic [1:0] MODE_IN_FRAME  = 2'd2;
    localparam logic [1:0] MODE_AFTER_ESC = 2'd3;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_FRAME);

    logic [1:0]        mode_reg, mode_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] start_reg, end_reg, escape_reg;
    logic              deliver_reg;
    logic              is_esc, is_start, is_end, full;

    assign is_esc   = (rx_byte == escape_reg);
    assign is_start = (rx_byte == start_reg);
    assign is_end   = (rx_byte == end_reg);
    assign full     = (fill_reg == FULL_COUNT);

    always_comb
    begin
        mode_next = mode_reg;
        fill_next = fill_reg;
        wr.we     = 1'b0;
        wr.addr   = fill_reg[ADDR_W-1:0];
        wr.data   = rx_byte;
        evt.fire  = 1'b0;
        evt.empty = (fill_reg == '0);
        evt.count = fill_reg;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_WAIT:
                begin
                    if (is_esc)
                    begin
                        mode_next = MODE_WAIT_ESC;
                    end
                    else if (is_start)
                    begin
                        mode_next = MODE_IN_FRAME;
                    end
                end
                MODE_WAIT_ESC:
                begin
                    mode_next = MODE_WAIT;
                end
                MODE_IN_FRAME:
                begin
                    if (is_esc)
                    begin
                        mode_next = MODE_AFTER_ESC;
                    end
                    else if (is_start)
                    begin
                        fill_next = '0;
                    end
                    else if (is_end)
                    begin
                        evt.fire  = deliver_reg;
                        fill_next = '0;
                        mode_next = MODE_WAIT;
                    end
                    else if (full)
                    begin
                        fill_next = '0;
                        mode_next = MODE_WAIT;
                    end
                    else
                    begin
                        wr.we     = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                MODE_AFTER_ESC:
                begin
                    mode_next = MODE_IN_FRAME;
                    if (full)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        wr.we     = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    mode_next = MODE_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_WAIT;
            fill_reg    <= '0;
            start_reg   <= 8'd126;
            end_reg     <= 8'd127;
            escape_reg  <= 8'd125;
            deliver_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_MARKER:   start_reg   <= cfg_data;
                    REG_END_MARKER:     end_reg     <= cfg_data;
                    REG_ESCAPE_MARKER:  escape_reg  <= cfg_data;
                    REG_DELIVER_ENABLE: deliver_reg <= cfg_data[0];
                    default:            deliver_reg <= deliver_reg;
                endcase
            end
        end
    end

endmodule

// ===== sv/escaped_frame_deframer.sv =====
`timescale 1ns / 1ps
// Takes one received byte per cycle while no completed frame is being delivered
// and the output is not stalled. An empty-frame result is registered in the cycle
// after the closing byte's transfer. A stored frame is read back from the frame
// memory via a read and a load state per byte; input stalls throughout.
// Reset clears mode, fill count and out_valid; markers return to their defaults.

module escaped_frame_deframer
    import ecfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic                 last_byte,
    output logic                 empty_frame,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] payload_reg, payload_next;
    logic              last_reg, last_next;
    logic              empty_reg, empty_next;
    logic              accept, out_free, rd_en, at_last, load;
    logic [BYTE_W-1:0] rd_data;
    ecfd_wr_t          wr;
    ecfd_evt_t         evt;

    assign in_stall     = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept       = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign at_last      = ((CNT_W'(idx_reg) + CNT_W'(1)) == len_reg);
    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_reg;
    assign last_byte    = last_reg;
    assign empty_frame  = empty_reg;

    ecfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .wr        (wr),
        .evt       (evt)
    );

    ecfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        rd_en          = 1'b0;
        load           = 1'b0;
        payload_next   = payload_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.fire && evt.empty)
                begin
                    load         = 1'b1;
                    payload_next = '0;
                    last_next    = 1'b1;
                    empty_next   = 1'b1;
                end
                else if (evt.fire)
                begin
                    len_next   = evt.count;
                    idx_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    payload_next = rd_data;
                    last_next    = at_last;
                    empty_next   = 1'b0;
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        len_reg     <= len_next;
        payload_reg <= payload_next;
        last_reg    <= last_next;
        empty_reg   <= empty_next;
    end

endmodule
